// ----- design/ldpm_pkg.sv -----
// ----------------------------------------------------------------------------
// ldpm_pkg: shared types and constants for the lens distortion point map
// Working format is signed Q19.28 in 48 bits, saturated to +-(2^47 - 1).
// ----------------------------------------------------------------------------
package ldpm_pkg;

   localparam int WORK_W  = 48;          // working value width
   localparam int MAG_W   = WORK_W - 1;  // magnitude of a working value
   localparam int FRAC_W  = 28;          // fraction bits of a working value
   localparam int HALF_W  = 24;          // low slice of a magnitude for partial products
   localparam int PROD_W  = 2 * MAG_W;   // full magnitude product
   localparam int MUL_LAT = 4;           // multiplier pipeline depth

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_ADDR_W-1:0] CSR_FOCAL_X         = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FOCAL_Y         = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_PRINCIPAL_POINT = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_RADIAL_K1       = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_RADIAL_K2       = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_RADIAL_K3       = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_TANGENTIAL_P1   = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_TANGENTIAL_P2   = 3'd7;

   localparam logic [31:0] FOCAL_RESET = 32'h0001_0000;  // 1.0 in Q16.16

   localparam logic [MAG_W-1:0] WORK_MAX = '1;

   typedef logic signed [WORK_W-1:0] work_type;

   localparam work_type WORK_ONE = 48'h0000_1000_0000;   // 1.0 in Q19.28

   // working value with its saturation flag
   typedef struct packed {
      logic     ovf;
      work_type value;
   } wval_type;

endpackage

// ----- design/lens_distortion_point_map_top.sv -----
// ----------------------------------------------------------------------------
// lens_distortion_point_map_top: five-coefficient radial/tangential lens map
// Throughput: one point per cycle; busy stays low, the pipeline never stalls.
// The depth is set by six dependent multiplies, each a 4-stage unit, plus the
// input register and five adder stages on the longest path.
// Reset clears the pipeline valid bits and loads the register defaults
// (focal lengths 1.0, everything else 0). The receiver cannot stall.
// ----------------------------------------------------------------------------
module lens_distortion_point_map_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [31:0]                req_norm_x,
   input  logic signed [31:0]                req_norm_y,
   output logic                              rsp_strobe,
   output logic signed [31:0]                rsp_pixel_x,
   output logic signed [31:0]                rsp_pixel_y,
   output logic                              rsp_clipped,
   input  logic                              csr_we,
   input  logic [ldpm_pkg::CSR_ADDR_W-1:0]   csr_index,
   input  logic [ldpm_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int LAST = 30;   // stage of the output register

   typedef struct packed {
      logic               sat;
      logic signed [31:0] value;
   } pix_type;

   localparam logic signed [ldpm_pkg::WORK_W:0] WSUM_MAX = {2'b00, ldpm_pkg::WORK_MAX};
   localparam logic signed [ldpm_pkg::WORK_W:0] PIX_MAX  = 49'sh7FFF_FFFF;
   localparam logic signed [ldpm_pkg::WORK_W:0] PIX_MIN  = -49'sh8000_0000;

   // saturating add of two working values
   function automatic ldpm_pkg::wval_type sat_add(ldpm_pkg::work_type a,
                                                  ldpm_pkg::work_type b);
      logic signed [ldpm_pkg::WORK_W:0] sum;
      ldpm_pkg::wval_type               res;
      sum = {a[ldpm_pkg::WORK_W-1], a} + {b[ldpm_pkg::WORK_W-1], b};
      res.ovf   = 1'b1;
      res.value = sum[ldpm_pkg::WORK_W-1:0];
      if (sum > WSUM_MAX) begin
         res.value = {1'b0, ldpm_pkg::WORK_MAX};
      end else if (sum < -WSUM_MAX) begin
         res.value = -{1'b0, ldpm_pkg::WORK_MAX};
      end else begin
         res.ovf = 1'b0;
      end
      return res;
   endfunction

   // add the principal point and clamp to a signed 32-bit pixel coordinate
   function automatic pix_type to_pixel(ldpm_pkg::work_type d, logic [31:0] ctr);
      logic signed [ldpm_pkg::WORK_W:0] sum;
      pix_type                          res;
      sum = {d[ldpm_pkg::WORK_W-1], d} + {17'b0, ctr};
      res.sat   = 1'b1;
      res.value = sum[31:0];
      if (sum > PIX_MAX) begin
         res.value = PIX_MAX[31:0];
      end else if (sum < PIX_MIN) begin
         res.value = PIX_MIN[31:0];
      end else begin
         res.sat = 1'b0;
      end
      return res;
   endfunction

   // -------------------------------------------------------------------------
   // Configuration registers
   // -------------------------------------------------------------------------
   logic [31:0]        focal_x_ff, focal_y_ff;
   logic [63:0]        center_ff;
   logic signed [31:0] k1_ff, k2_ff, k3_ff, p1_ff, p2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff <= ldpm_pkg::FOCAL_RESET;
         focal_y_ff <= ldpm_pkg::FOCAL_RESET;
         center_ff  <= '0;
         k1_ff      <= '0;
         k2_ff      <= '0;
         k3_ff      <= '0;
         p1_ff      <= '0;
         p2_ff      <= '0;
      end else if (csr_we) begin
         case (csr_index)
            ldpm_pkg::CSR_FOCAL_X:         focal_x_ff <= csr_wdata[31:0];
            ldpm_pkg::CSR_FOCAL_Y:         focal_y_ff <= csr_wdata[31:0];
            ldpm_pkg::CSR_PRINCIPAL_POINT: center_ff  <= csr_wdata;
            ldpm_pkg::CSR_RADIAL_K1:       k1_ff      <= csr_wdata[31:0];
            ldpm_pkg::CSR_RADIAL_K2:       k2_ff      <= csr_wdata[31:0];
            ldpm_pkg::CSR_RADIAL_K3:       k3_ff      <= csr_wdata[31:0];
            ldpm_pkg::CSR_TANGENTIAL_P1:   p1_ff      <= csr_wdata[31:0];
            ldpm_pkg::CSR_TANGENTIAL_P2:   p2_ff      <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // Coefficients move from Q5.26 to Q19.28 by a shift of 2 (exact); the
   // doubled tangential terms take one more bit and cannot overflow.
   ldpm_pkg::work_type k1_w, k2_w, k3_w, p1_w, p2_w, p1x2_w, p2x2_w;
   ldpm_pkg::work_type focal_x_w, focal_y_w;

   assign k1_w      = {{14{k1_ff[31]}}, k1_ff, 2'b00};
   assign k2_w      = {{14{k2_ff[31]}}, k2_ff, 2'b00};
   assign k3_w      = {{14{k3_ff[31]}}, k3_ff, 2'b00};
   assign p1_w      = {{14{p1_ff[31]}}, p1_ff, 2'b00};
   assign p2_w      = {{14{p2_ff[31]}}, p2_ff, 2'b00};
   assign p1x2_w    = {{13{p1_ff[31]}}, p1_ff, 3'b000};
   assign p2x2_w    = {{13{p2_ff[31]}}, p2_ff, 3'b000};
   assign focal_x_w = {16'b0, focal_x_ff};
   assign focal_y_w = {16'b0, focal_y_ff};

   // -------------------------------------------------------------------------
   // Pipeline. The number in each register name range is the stage at which
   // the value sits in that register.
   // -------------------------------------------------------------------------
   logic               vld_ff  [1:LAST];
   logic               flag_ff [6:LAST];
   logic [LAST-1:5]    evt;

   logic signed [31:0] x_ff [1:19];
   logic signed [31:0] y_ff [1:19];
   ldpm_pkg::work_type x_w, y_w, x19_w, y19_w;

   assign x_w   = {{16{x_ff[1][31]}}, x_ff[1]};
   assign y_w   = {{16{y_ff[1][31]}}, y_ff[1]};
   assign x19_w = {{16{x_ff[19][31]}}, x_ff[19]};
   assign y19_w = {{16{y_ff[19][31]}}, y_ff[19]};

   // multiplier outputs, each 4 stages after its operands
   ldpm_pkg::wval_type pr_xx, pr_yy, pr_xy;          // stage 5
   ldpm_pkg::wval_type pr_t1x, pr_t2y;               // stage 9
   ldpm_pkg::wval_type pr_r4, pr_k1r2;               // stage 10
   ldpm_pkg::wval_type pr_t2x, pr_t1y;               // stage 11
   ldpm_pkg::wval_type pr_r6, pr_k2r4;               // stage 14
   ldpm_pkg::wval_type pr_k3r6;                      // stage 18
   ldpm_pkg::wval_type pr_xd0, pr_yd0;               // stage 23
   ldpm_pkg::wval_type pr_px, pr_py;                 // stage 29

   // sums
   ldpm_pkg::wval_type r2_in, xx2_in, yy2_in, tx_in, ty_in;
   ldpm_pkg::wval_type rad1_in, rad2_in, rad_in;
   ldpm_pkg::wval_type xd1_in, yd1_in, xd_in, yd_in;
   pix_type            pix_x_in, pix_y_in;

   ldpm_pkg::work_type r2_ff   [6:10];
   ldpm_pkg::work_type xx2_ff, yy2_ff, tx_ff, ty_ff;
   ldpm_pkg::work_type rad1_ff [11:14];
   ldpm_pkg::work_type rad2_ff [15:18];
   ldpm_pkg::work_type rad_ff;
   ldpm_pkg::work_type t1x_ff  [10:23];
   ldpm_pkg::work_type t1y_ff  [12:23];
   ldpm_pkg::work_type t2x_ff  [12:24];
   ldpm_pkg::work_type t2y_ff  [10:24];
   ldpm_pkg::work_type xd1_ff, yd1_ff, xd_ff, yd_ff;
   logic signed [31:0] pix_x_ff, pix_y_ff;

   // squares and cross term
   ldpm_mul u_mul_xx (.clock(clock), .op_a(x_w), .op_b(x_w), .prod(pr_xx));
   ldpm_mul u_mul_yy (.clock(clock), .op_a(y_w), .op_b(y_w), .prod(pr_yy));
   ldpm_mul u_mul_xy (.clock(clock), .op_a(x_w), .op_b(y_w), .prod(pr_xy));

   // tangential products against x*y
   ldpm_mul u_mul_t1x (.clock(clock), .op_a(p1x2_w), .op_b(pr_xy.value), .prod(pr_t1x));
   ldpm_mul u_mul_t2y (.clock(clock), .op_a(p2x2_w), .op_b(pr_xy.value), .prod(pr_t2y));

   // powers of r2 and radial products
   ldpm_mul u_mul_r4  (.clock(clock), .op_a(r2_ff[6]), .op_b(r2_ff[6]), .prod(pr_r4));
   ldpm_mul u_mul_k1  (.clock(clock), .op_a(k1_w), .op_b(r2_ff[6]), .prod(pr_k1r2));
   ldpm_mul u_mul_r6  (.clock(clock), .op_a(pr_r4.value), .op_b(r2_ff[10]), .prod(pr_r6));
   ldpm_mul u_mul_k2  (.clock(clock), .op_a(k2_w), .op_b(pr_r4.value), .prod(pr_k2r4));
   ldpm_mul u_mul_k3  (.clock(clock), .op_a(k3_w), .op_b(pr_r6.value), .prod(pr_k3r6));

   // tangential products against r2 + 2x^2 and r2 + 2y^2
   ldpm_mul u_mul_t2x (.clock(clock), .op_a(p2_w), .op_b(tx_ff), .prod(pr_t2x));
   ldpm_mul u_mul_t1y (.clock(clock), .op_a(p1_w), .op_b(ty_ff), .prod(pr_t1y));

   // radial scaling of the point
   ldpm_mul u_mul_xd (.clock(clock), .op_a(x19_w), .op_b(rad_ff), .prod(pr_xd0));
   ldpm_mul u_mul_yd (.clock(clock), .op_a(y19_w), .op_b(rad_ff), .prod(pr_yd0));

   // focal scaling
   ldpm_mul u_mul_px (.clock(clock), .op_a(xd_ff), .op_b(focal_x_w), .prod(pr_px));
   ldpm_mul u_mul_py (.clock(clock), .op_a(yd_ff), .op_b(focal_y_w), .prod(pr_py));

   // adders, in the order of the formula so saturation lands the same way
   always_comb begin
      r2_in    = sat_add(pr_xx.value, pr_yy.value);
      xx2_in   = sat_add(pr_xx.value, pr_xx.value);
      yy2_in   = sat_add(pr_yy.value, pr_yy.value);
      tx_in    = sat_add(r2_ff[6], xx2_ff);
      ty_in    = sat_add(r2_ff[6], yy2_ff);
      rad1_in  = sat_add(ldpm_pkg::WORK_ONE, pr_k1r2.value);
      rad2_in  = sat_add(rad1_ff[14], pr_k2r4.value);
      rad_in   = sat_add(rad2_ff[18], pr_k3r6.value);
      xd1_in   = sat_add(pr_xd0.value, t1x_ff[23]);
      yd1_in   = sat_add(pr_yd0.value, t1y_ff[23]);
      xd_in    = sat_add(xd1_ff, t2x_ff[24]);
      yd_in    = sat_add(yd1_ff, t2y_ff[24]);
      pix_x_in = to_pixel(pr_px.value, center_ff[31:0]);
      pix_y_in = to_pixel(pr_py.value, center_ff[63:32]);
   end

   // saturation events, indexed by the stage they leave
   always_comb begin
      evt      = '0;
      evt[5]   = pr_xx.ovf | pr_yy.ovf | pr_xy.ovf | r2_in.ovf | xx2_in.ovf | yy2_in.ovf;
      evt[6]   = tx_in.ovf | ty_in.ovf;
      evt[9]   = pr_t1x.ovf | pr_t2y.ovf;
      evt[10]  = pr_r4.ovf | pr_k1r2.ovf | rad1_in.ovf;
      evt[11]  = pr_t2x.ovf | pr_t1y.ovf;
      evt[14]  = pr_r6.ovf | pr_k2r4.ovf | rad2_in.ovf;
      evt[18]  = pr_k3r6.ovf | rad_in.ovf;
      evt[23]  = pr_xd0.ovf | pr_yd0.ovf | xd1_in.ovf | yd1_in.ovf;
      evt[24]  = xd_in.ovf | yd_in.ovf;
      evt[29]  = pr_px.ovf | pr_py.ovf | pix_x_in.sat | pix_y_in.sat;
   end

   // valid bits travel with the data; clear them on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= LAST; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         vld_ff[1] <= start;
         for (int i = 2; i <= LAST; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // payload: free-running, advance every cycle
   always_ff @(posedge clock) begin
      x_ff[1] <= req_norm_x;
      y_ff[1] <= req_norm_y;
      for (int i = 2; i <= 19; i++) begin
         x_ff[i] <= x_ff[i-1];
         y_ff[i] <= y_ff[i-1];
      end

      flag_ff[6] <= evt[5];
      for (int i = 7; i <= LAST; i++) begin
         flag_ff[i] <= flag_ff[i-1] | evt[i-1];
      end

      r2_ff[6] <= r2_in.value;
      for (int i = 7; i <= 10; i++) begin
         r2_ff[i] <= r2_ff[i-1];
      end
      xx2_ff <= xx2_in.value;
      yy2_ff <= yy2_in.value;
      tx_ff  <= tx_in.value;
      ty_ff  <= ty_in.value;

      rad1_ff[11] <= rad1_in.value;
      for (int i = 12; i <= 14; i++) begin
         rad1_ff[i] <= rad1_ff[i-1];
      end
      rad2_ff[15] <= rad2_in.value;
      for (int i = 16; i <= 18; i++) begin
         rad2_ff[i] <= rad2_ff[i-1];
      end
      rad_ff <= rad_in.value;

      // hold the tangential terms until the radial part catches up
      t1x_ff[10] <= pr_t1x.value;
      t2y_ff[10] <= pr_t2y.value;
      for (int i = 11; i <= 23; i++) begin
         t1x_ff[i] <= t1x_ff[i-1];
      end
      for (int i = 11; i <= 24; i++) begin
         t2y_ff[i] <= t2y_ff[i-1];
      end
      t2x_ff[12] <= pr_t2x.value;
      t1y_ff[12] <= pr_t1y.value;
      for (int i = 13; i <= 23; i++) begin
         t1y_ff[i] <= t1y_ff[i-1];
      end
      for (int i = 13; i <= 24; i++) begin
         t2x_ff[i] <= t2x_ff[i-1];
      end

      xd1_ff   <= xd1_in.value;
      yd1_ff   <= yd1_in.value;
      xd_ff    <= xd_in.value;
      yd_ff    <= yd_in.value;
      pix_x_ff <= pix_x_in.value;
      pix_y_ff <= pix_y_in.value;
   end

   // every cycle takes a new point
   assign busy = 1'b0;

   // one-cycle result strobe from the last stage
   assign rsp_strobe  = vld_ff[LAST];
   assign rsp_pixel_x = pix_x_ff;
   assign rsp_pixel_y = pix_y_ff;
   assign rsp_clipped = flag_ff[LAST];

endmodule

// ----- design/ldpm_mul.sv -----
// ----------------------------------------------------------------------------
// ldpm_mul: pipelined saturating fixed-point multiplier
// Sign-magnitude product of two working values, shifted right by the
// fraction width with truncation of the magnitude, saturated symmetrically.
// ----------------------------------------------------------------------------
module ldpm_mul (
   input  logic               clock,
   input  ldpm_pkg::work_type op_a,
   input  ldpm_pkg::work_type op_b,
   output ldpm_pkg::wval_type prod
);

   localparam int HI_W  = ldpm_pkg::MAG_W - ldpm_pkg::HALF_W;
   localparam int TOP_B = ldpm_pkg::MAG_W + ldpm_pkg::FRAC_W;

   ldpm_pkg::work_type abs_a;
   ldpm_pkg::work_type abs_b;
   logic [ldpm_pkg::MAG_W-1:0] mag_a_ff;
   logic [ldpm_pkg::MAG_W-1:0] mag_b_ff;
   logic                       neg_ff [1:3];

   logic [2*ldpm_pkg::HALF_W-1:0]      ll_in, ll_ff;
   logic [HI_W+ldpm_pkg::HALF_W-1:0]   m1_in, m1_ff;
   logic [HI_W+ldpm_pkg::HALF_W-1:0]   m2_in, m2_ff;
   logic [2*HI_W-1:0]                  hh_in, hh_ff;
   logic [ldpm_pkg::PROD_W-1:0]        full_in, full_ff;
   logic [ldpm_pkg::MAG_W-1:0]         mag;
   ldpm_pkg::work_type                 mag_w;
   ldpm_pkg::wval_type                 prod_in, prod_ff;

   // stage 1: magnitudes and sign
   assign abs_a = op_a[ldpm_pkg::WORK_W-1] ? -op_a : op_a;
   assign abs_b = op_b[ldpm_pkg::WORK_W-1] ? -op_b : op_b;

   // stage 2: four partial products
   assign ll_in = mag_a_ff[ldpm_pkg::HALF_W-1:0] * mag_b_ff[ldpm_pkg::HALF_W-1:0];
   assign m1_in = mag_a_ff[ldpm_pkg::MAG_W-1:ldpm_pkg::HALF_W] *
                  mag_b_ff[ldpm_pkg::HALF_W-1:0];
   assign m2_in = mag_a_ff[ldpm_pkg::HALF_W-1:0] *
                  mag_b_ff[ldpm_pkg::MAG_W-1:ldpm_pkg::HALF_W];
   assign hh_in = mag_a_ff[ldpm_pkg::MAG_W-1:ldpm_pkg::HALF_W] *
                  mag_b_ff[ldpm_pkg::MAG_W-1:ldpm_pkg::HALF_W];

   // stage 3: combine
   assign full_in = {hh_ff, ll_ff}
                  + (ldpm_pkg::PROD_W'(m1_ff) << ldpm_pkg::HALF_W)
                  + (ldpm_pkg::PROD_W'(m2_ff) << ldpm_pkg::HALF_W);

   // stage 4: shift, saturate, restore sign
   always_comb begin
      prod_in.ovf   = |full_ff[ldpm_pkg::PROD_W-1:TOP_B];
      mag           = prod_in.ovf ? ldpm_pkg::WORK_MAX
                                  : full_ff[TOP_B-1:ldpm_pkg::FRAC_W];
      mag_w         = {1'b0, mag};
      prod_in.value = neg_ff[3] ? -mag_w : mag_w;
   end

   always_ff @(posedge clock) begin
      mag_a_ff  <= abs_a[ldpm_pkg::MAG_W-1:0];
      mag_b_ff  <= abs_b[ldpm_pkg::MAG_W-1:0];
      neg_ff[1] <= op_a[ldpm_pkg::WORK_W-1] ^ op_b[ldpm_pkg::WORK_W-1];
      neg_ff[2] <= neg_ff[1];
      neg_ff[3] <= neg_ff[2];
      ll_ff     <= ll_in;
      m1_ff     <= m1_in;
      m2_ff     <= m2_in;
      hh_ff     <= hh_in;
      full_ff   <= full_in;
      prod_ff   <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ----- bench/ldpm_point_checker.sv -----
// ----------------------------------------------------------------------------
// ldpm_point_checker: scoreboard for the lens distortion point map
// Watches the register port and both channels, works out the distorted pixel
// of every accepted point in Q19.28 and compares each result with it in order.
// ----------------------------------------------------------------------------
module ldpm_point_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic signed [31:0]                  req_norm_x,
   input  logic signed [31:0]                  req_norm_y,
   input  logic                                rsp_strobe,
   input  logic signed [31:0]                  rsp_pixel_x,
   input  logic signed [31:0]                  rsp_pixel_y,
   input  logic                                rsp_clipped,
   input  logic                                csr_we,
   input  logic [ldpm_pkg::CSR_ADDR_W-1:0]     csr_index,
   input  logic [ldpm_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int                                  points_in_flight,
   output int                                  mismatches
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [63:0] wide_type;

   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic               clip;
   } pixel_type;

   localparam wide_type WORK_LIMIT = (64'sd1 <<< ldpm_pkg::MAG_W) - 64'sd1;
   localparam wide_type UNITY      = ldpm_pkg::WORK_ONE;
   localparam wide_type PIX_MAX    = 64'sd2147483647;
   localparam wide_type PIX_MIN    = -64'sd2147483648;

   logic [31:0]        lens_focal_x = ldpm_pkg::FOCAL_RESET;
   logic [31:0]        lens_focal_y = ldpm_pkg::FOCAL_RESET;
   logic [63:0]        lens_center  = '0;
   logic signed [31:0] coef_k1 = '0, coef_k2 = '0, coef_k3 = '0;
   logic signed [31:0] coef_p1 = '0, coef_p2 = '0;

   pixel_type expected_pixels[$];
   logic      clip_seen;
   int        fault_count = 0;
   int        held = 0;

   assign points_in_flight = held;
   assign mismatches       = fault_count;

   function automatic wide_type add_sat(input wide_type a, input wide_type b);
      wide_type s;
      s = a + b;
      if (s > WORK_LIMIT) begin
         clip_seen = 1'b1;
         s = WORK_LIMIT;
      end else if (s < -WORK_LIMIT) begin
         clip_seen = 1'b1;
         s = -WORK_LIMIT;
      end
      return s;
   endfunction

   // exact product, magnitude truncated by the fraction shift, then saturated
   function automatic wide_type mul_q28(input wide_type a, input wide_type b);
      logic [63:0]  ma, mb;
      logic [127:0] prod;
      wide_type     mag;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      prod = {64'd0, ma} * {64'd0, mb};
      prod = prod >> ldpm_pkg::FRAC_W;
      if (prod > {64'd0, WORK_LIMIT}) begin
         clip_seen = 1'b1;
         prod = {64'd0, WORK_LIMIT};
      end
      mag = prod[63:0];
      return ((a < 0) != (b < 0)) ? -mag : mag;
   endfunction

   function automatic logic signed [31:0] to_pixel(input wide_type d,
                                                   input logic [31:0] focal,
                                                   input logic [31:0] centre);
      wide_type v;
      v = mul_q28(d, $signed({32'd0, focal})) + $signed({32'd0, centre});
      if (v > PIX_MAX) begin
         clip_seen = 1'b1;
         v = PIX_MAX;
      end else if (v < PIX_MIN) begin
         clip_seen = 1'b1;
         v = PIX_MIN;
      end
      return v[31:0];
   endfunction

   function automatic pixel_type map_point(input logic signed [31:0] nx,
                                           input logic signed [31:0] ny);
      wide_type  x, y, k1, k2, k3, t1, t2;
      wide_type  xx, yy, xy, r2, r4, r6, radial, xd, yd;
      pixel_type px;
      clip_seen = 1'b0;
      x  = nx;
      y  = ny;
      k1 = coef_k1;
      k2 = coef_k2;
      k3 = coef_k3;
      t1 = coef_p1;
      t2 = coef_p2;
      // Q5.26 coefficients line up with Q19.28
      k1 = k1 <<< 2;
      k2 = k2 <<< 2;
      k3 = k3 <<< 2;
      t1 = t1 <<< 2;
      t2 = t2 <<< 2;

      xx = mul_q28(x, x);
      yy = mul_q28(y, y);
      xy = mul_q28(x, y);
      r2 = add_sat(xx, yy);
      r4 = mul_q28(r2, r2);
      r6 = mul_q28(r4, r2);

      radial = add_sat(UNITY, mul_q28(k1, r2));
      radial = add_sat(radial, mul_q28(k2, r4));
      radial = add_sat(radial, mul_q28(k3, r6));

      xd = mul_q28(x, radial);
      xd = add_sat(xd, mul_q28(add_sat(t1, t1), xy));
      xd = add_sat(xd, mul_q28(t2, add_sat(r2, add_sat(xx, xx))));

      yd = mul_q28(y, radial);
      yd = add_sat(yd, mul_q28(t1, add_sat(r2, add_sat(yy, yy))));
      yd = add_sat(yd, mul_q28(add_sat(t2, t2), xy));

      px.px   = to_pixel(xd, lens_focal_x, lens_center[31:0]);
      px.py   = to_pixel(yd, lens_focal_y, lens_center[63:32]);
      px.clip = clip_seen;
      return px;
   endfunction

   task automatic flag_error(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      fault_count++;
   endtask

   always @(posedge clock) begin : watch
      pixel_type want;
      if (reset) begin
         lens_focal_x = ldpm_pkg::FOCAL_RESET;
         lens_focal_y = ldpm_pkg::FOCAL_RESET;
         lens_center  = '0;
         coef_k1 = '0;
         coef_k2 = '0;
         coef_k3 = '0;
         coef_p1 = '0;
         coef_p2 = '0;
         expected_pixels.delete();
      end else begin
         // results leave before this edge's point can be counted
         if (rsp_strobe) begin
            if (expected_pixels.size() == 0) begin
               flag_error("result with no point outstanding");
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_pixel_x !== want.px)
                  flag_error($sformatf("pixel_x got %0d want %0d", rsp_pixel_x, want.px));
               if (rsp_pixel_y !== want.py)
                  flag_error($sformatf("pixel_y got %0d want %0d", rsp_pixel_y, want.py));
               if (rsp_clipped !== want.clip)
                  flag_error($sformatf("clipped got %b want %b", rsp_clipped, want.clip));
            end
         end
         if (start && !busy)
            expected_pixels.push_back(map_point(req_norm_x, req_norm_y));
         if (csr_we) begin
            case (csr_index)
               ldpm_pkg::CSR_FOCAL_X:         lens_focal_x = csr_wdata[31:0];
               ldpm_pkg::CSR_FOCAL_Y:         lens_focal_y = csr_wdata[31:0];
               ldpm_pkg::CSR_PRINCIPAL_POINT: lens_center  = csr_wdata;
               ldpm_pkg::CSR_RADIAL_K1:       coef_k1      = csr_wdata[31:0];
               ldpm_pkg::CSR_RADIAL_K2:       coef_k2      = csr_wdata[31:0];
               ldpm_pkg::CSR_RADIAL_K3:       coef_k3      = csr_wdata[31:0];
               ldpm_pkg::CSR_TANGENTIAL_P1:   coef_p1      = csr_wdata[31:0];
               ldpm_pkg::CSR_TANGENTIAL_P2:   coef_p2      = csr_wdata[31:0];
               default: ;
            endcase
         end
      end
      held <= expected_pixels.size();
   end

endmodule

// ----- bench/tb_lens_distortion_point_map_top.sv -----
// ----------------------------------------------------------------------------
// tb_lens_distortion_point_map_top: stimulus and verdict for the lens map
// Drives points in random bursts through several lens settings (defaults, a
// typical camera, both coefficient extremes, zero focal length, random sets)
// while a separate checker predicts and compares every pixel result.
// ----------------------------------------------------------------------------
module tb_lens_distortion_point_map_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic signed [31:0] Q28_ONE  = 32'sh1000_0000;
   localparam logic signed [31:0] COORD_HI = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] COORD_LO = 32'sh8000_0000;
   localparam int                 RANDOM_PHASES    = 10;
   localparam int                 POINTS_PER_PHASE = 115;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                start = 1'b0;
   logic                                busy;
   logic signed [31:0]                  req_norm_x = '0;
   logic signed [31:0]                  req_norm_y = '0;
   logic                                rsp_strobe;
   logic signed [31:0]                  rsp_pixel_x;
   logic signed [31:0]                  rsp_pixel_y;
   logic                                rsp_clipped;
   logic                                csr_we = 1'b0;
   logic [ldpm_pkg::CSR_ADDR_W-1:0]     csr_index = '0;
   logic [ldpm_pkg::CSR_DATA_W-1:0]     csr_wdata = '0;

   int points_in_flight;
   int mismatches;
   int burst_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   lens_distortion_point_map_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_norm_x  (req_norm_x),
      .req_norm_y  (req_norm_y),
      .rsp_strobe  (rsp_strobe),
      .rsp_pixel_x (rsp_pixel_x),
      .rsp_pixel_y (rsp_pixel_y),
      .rsp_clipped (rsp_clipped),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   ldpm_point_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_norm_x       (req_norm_x),
      .req_norm_y       (req_norm_y),
      .rsp_strobe       (rsp_strobe),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_clipped      (rsp_clipped),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .points_in_flight (points_in_flight),
      .mismatches       (mismatches)
   );

   // Present one register write for a single edge. The caller drops csr_we
   // once the whole batch is out, so the enable never toggles within a step.
   task automatic csr_write(input logic [ldpm_pkg::CSR_ADDR_W-1:0] idx,
                            input logic [ldpm_pkg::CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Write the full lens setting. The unused upper half of every 32-bit
   // register carries junk, which the block must drop.
   task automatic load_lens(input logic [31:0] fx, input logic [31:0] fy,
                            input logic [63:0] center,
                            input logic [31:0] k1, input logic [31:0] k2,
                            input logic [31:0] k3,
                            input logic [31:0] p1, input logic [31:0] p2);
      csr_write(ldpm_pkg::CSR_FOCAL_X,         {$urandom, fx});
      csr_write(ldpm_pkg::CSR_FOCAL_Y,         {$urandom, fy});
      csr_write(ldpm_pkg::CSR_PRINCIPAL_POINT, center);
      csr_write(ldpm_pkg::CSR_RADIAL_K1,       {$urandom, k1});
      csr_write(ldpm_pkg::CSR_RADIAL_K2,       {$urandom, k2});
      csr_write(ldpm_pkg::CSR_RADIAL_K3,       {$urandom, k3});
      csr_write(ldpm_pkg::CSR_TANGENTIAL_P1,   {$urandom, p1});
      csr_write(ldpm_pkg::CSR_TANGENTIAL_P2,   {$urandom, p2});
      csr_we <= 1'b0;
   endtask

   // Pick a lens setting: mostly a plausible camera (coefficients within
   // +-1.0, focal 100..2000 px), sometimes fully random register contents.
   task automatic load_random_lens();
      logic [31:0] coef [5];
      logic [31:0] fx, fy;
      logic [63:0] center;
      bit          wild;
      wild = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 5; i++)
         coef[i] = wild ? $urandom : $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
      fx = wild ? $urandom : $urandom_range(32'h0064_0000, 32'h07D0_0000);
      fy = wild ? $urandom : $urandom_range(32'h0064_0000, 32'h07D0_0000);
      center = wild ? {$urandom, $urandom}
                    : {32'($urandom_range(0, 32'h07D0_0000)),
                       32'($urandom_range(0, 32'h07D0_0000))};
      load_lens(fx, fy, center, coef[0], coef[1], coef[2], coef[3], coef[4]);
   endtask

   // Mostly points inside +-2.0 where the lens model is meaningful; one in
   // four spans the whole Q3.28 range to hit every bit and the saturation paths.
   function automatic logic signed [31:0] random_coord();
      if ($urandom_range(0, 3) == 0)
         return $urandom;
      return $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
   endfunction

   // Offer one point and hold it until the transfer happens. Between bursts
   // drop start for a random gap; long bursts give stretches with no idling.
   task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y);
      start      <= 1'b1;
      req_norm_x <= x;
      req_norm_y <= y;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 12);
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end else begin
         burst_left--;
      end
   endtask

   // Drain the pipeline: advance until the checker holds no expectation.
   // The first edge lets the count catch up with the last transfer.
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (points_in_flight != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset setting: unit focal lengths, no distortion. Corners of the
      // coordinate range overflow r^6 inside, so clipped rises even here.
      send_point('0, '0);
      send_point(Q28_ONE, '0);
      send_point('0, -Q28_ONE);
      send_point(COORD_HI, COORD_HI);
      send_point(COORD_LO, COORD_LO);
      send_point(COORD_LO, COORD_HI);
      send_point(32'sh0000_0001, -32'sh0000_0001);
      send_point(32'sh0800_0000, 32'sh0400_0000);
      settle();

      // Typical camera: 600/590 px focal, centre (320.5, 240.25), barrel
      // distortion with small tangential terms.
      load_lens(32'h0258_0000, 32'h024E_0000, {32'h00F0_4000, 32'h0140_8000},
                -32'sd18790482, 32'sd4697620, -32'sd67109, 32'sd67109, -32'sd33554);
      send_point(Q28_ONE, '0);
      send_point('0, Q28_ONE);
      send_point(-Q28_ONE, -Q28_ONE);
      send_point(32'sh0400_0000, 32'sh04CC_CCCC);
      send_point(COORD_HI, COORD_LO);
      send_point('0, '0);
      settle();

      // Largest positive coefficients, focal lengths and principal point:
      // even the centre point saturates the pixel output.
      load_lens('1, '1, '1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point('0, '0);
      send_point(32'sh0000_0100, 32'sh0000_0100);
      send_point(COORD_HI, COORD_LO);
      send_point(COORD_LO, COORD_LO);
      settle();

      // Most negative coefficients with zero focal length: the pixel is the
      // principal point, clamped to the signed 32-bit range, whatever the distortion does.
      load_lens('0, '0, {32'h8000_0000, 32'h7FFF_FFFF}, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_point(COORD_HI, COORD_HI);
      send_point(32'sh0800_0000, -32'sh0800_0000);
      send_point('0, '0);
      send_point(COORD_LO, COORD_HI);
      settle();

      // Random part: a fresh lens setting per phase, registers written only
      // once the pipeline has drained.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         load_random_lens();
         repeat (POINTS_PER_PHASE) send_point(random_coord(), random_coord());
         settle();
      end

      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("tb_lens_distortion_point_map_top passed");
      else
         $display("tb_lens_distortion_point_map_top failed");
      $finish;
   end

   // Hard stop far beyond the slowest correct run.
   initial begin : watchdog
      #1_000_000;
      $display("tb_lens_distortion_point_map_top failed");
      $finish;
   end

endmodule
